### rtl/core/settings_record_checker_core_assert.svh
// Assertion helpers for the settings record checker.
`ifndef SETTINGS_RECORD_CHECKER_CORE_ASSERT_SVH
`define SETTINGS_RECORD_CHECKER_CORE_ASSERT_SVH

// Concurrent check on clk, off while rst is high, with its own message.
`define SRCHK_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check with a generic message.
`define SRCHK_ASSERT(lbl, prop) \
  `SRCHK_ASSERT_MSG(lbl, prop, "settings record checker assertion failed")

`endif

### rtl/core/srchk_pkg.sv
`default_nettype none

package srchk_pkg;

  // Record layout and check constants
  localparam int RECORD_BYTES = 32;
  localparam logic [31:0] MAGIC_WORD = 32'h5453_4955;
  localparam logic [15:0] RECORD_VERSION = 16'd1;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [7:0] FLAG_ERASED = 8'hFF;
  localparam logic [7:0] ROT_LIMIT_RESET = 8'd4;

  // One accepted record byte
  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } item_t;

  // Verdict and decoded fields of one record
  typedef struct packed {
    logic        record_ok;
    logic [31:0] sequence_number;
    logic [7:0]  rotation_code;
    logic        key_sound_on;
    logic        language_alt_on;
    logic        battery_alarm_on;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/srchk_in_stage.sv
`default_nettype none

module srchk_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire srchk_pkg::item_t in_item,
  input  wire logic            take,
  output logic                 item_valid,
  output srchk_pkg::item_t     item
);

  // Accept when empty or when the held byte moves on this cycle
  assign in_ready = !item_valid || take;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

### rtl/core/srchk_crc_byte.sv
`default_nettype none

module srchk_crc_byte (
  input  wire logic [31:0] crc_in,
  input  wire logic [7:0]  data,
  output logic [31:0]      crc_out
);

  // Reflected CRC-32, eight bit steps unrolled into xor logic
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ ({32{c[0]}} & srchk_pkg::CRC_POLY);
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

### rtl/core/srchk_tracker.sv
`default_nettype none

module srchk_tracker #(
  parameter int RecordBytes = srchk_pkg::RECORD_BYTES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire srchk_pkg::item_t item,
  input  wire logic [7:0]       rotation_limit,
  output logic                  emit,
  output srchk_pkg::result_t    result
);

  localparam int PosW = $clog2(RecordBytes);
  localparam int CheckOffset = RecordBytes - 4;
  localparam logic [PosW-1:0] LastPos = PosW'(RecordBytes - 1);

  logic [PosW-1:0] byte_position, pos, pos_next;
  logic [31:0] running_crc, crc_base, crc_step, crc_next;
  logic        fields_good, fields_base, fields_next;
  logic [23:0] header_low, header_base, header_next;
  logic [31:0] seq_capture, seq_base, seq_next;
  logic [7:0]  rotation, rotation_next;
  logic        key_sound, key_sound_next;
  logic        language_alt, language_alt_next;
  logic        battery_alarm, battery_alarm_next;
  logic [23:0] check_low, check_base, check_next;
  logic [1:0]  lane;
  logic        clr;
  logic [7:0]  b;

  // Position of this byte; a start mark forces byte 0
  assign b    = item.data;
  assign pos  = item.start ? '0 : byte_position;
  assign lane = pos[1:0];
  assign clr  = (pos == '0);
  assign emit = (pos == LastPos);
  assign pos_next = emit ? '0 : pos + 1'b1;

  // Restart all checking state at byte 0
  assign crc_base    = clr ? srchk_pkg::CRC_INIT : running_crc;
  assign fields_base = clr ? 1'b1 : fields_good;
  assign header_base = clr ? '0 : header_low;
  assign seq_base    = clr ? '0 : seq_capture;
  assign check_base  = clr ? '0 : check_low;

  srchk_crc_byte u_crc (
    .crc_in  (crc_base),
    .data    (b),
    .crc_out (crc_step)
  );

  assign crc_next = (pos < PosW'(CheckOffset)) ? crc_step : crc_base;

  // Insert byte into the field it belongs to and run header and range checks
  always_comb begin
    header_next        = header_base;
    seq_next           = seq_base;
    check_next         = check_base;
    fields_next        = fields_base;
    rotation_next      = rotation;
    key_sound_next     = key_sound;
    language_alt_next  = language_alt;
    battery_alarm_next = battery_alarm;

    if (pos < PosW'(8)) begin
      case (lane)
        2'd0: header_next[7:0]   = b;
        2'd1: header_next[15:8]  = b;
        2'd2: header_next[23:16] = b;
        default: ;
      endcase
      if (pos == PosW'(3) && {b, header_base} != srchk_pkg::MAGIC_WORD) begin
        fields_next = 1'b0;
      end
      if (pos == PosW'(7) &&
          {b, header_base} != {16'(RecordBytes), srchk_pkg::RECORD_VERSION}) begin
        fields_next = 1'b0;
      end
    end else if (pos < PosW'(12)) begin
      seq_next[{lane, 3'b000} +: 8] = b;
    end else if (pos < PosW'(16)) begin
      case (lane)
        2'd0: begin
          rotation_next = b;
          if (b >= rotation_limit) fields_next = 1'b0;
        end
        2'd1: begin
          key_sound_next = b[0];
          if (b > 8'd1) fields_next = 1'b0;
        end
        2'd2: begin
          language_alt_next = (b == 8'd1);
          if (b != srchk_pkg::FLAG_ERASED && b > 8'd1) fields_next = 1'b0;
        end
        default: begin
          battery_alarm_next = (b == 8'd1);
          if (b != srchk_pkg::FLAG_ERASED && b > 8'd1) fields_next = 1'b0;
        end
      endcase
    end else if (pos >= PosW'(CheckOffset)) begin
      case (lane)
        2'd0: check_next[7:0]   = b;
        2'd1: check_next[15:8]  = b;
        2'd2: check_next[23:16] = b;
        default: ;
      endcase
    end
  end

  // Verdict on the last byte; stored check word completes with this byte
  always_comb begin
    result.record_ok = fields_next &&
        ((crc_next ^ srchk_pkg::CRC_INIT) == {b, check_base});
    result.sequence_number  = seq_next;
    result.rotation_code    = rotation_next;
    result.key_sound_on     = key_sound_next;
    result.language_alt_on  = language_alt_next;
    result.battery_alarm_on = battery_alarm_next;
  end

  // Advance position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (go) begin
      byte_position <= pos_next;
    end
  end

  // Update record state
  always_ff @(posedge clk) begin
    if (go) begin
      running_crc   <= crc_next;
      fields_good   <= fields_next;
      header_low    <= header_next;
      seq_capture   <= seq_next;
      rotation      <= rotation_next;
      key_sound     <= key_sound_next;
      language_alt  <= language_alt_next;
      battery_alarm <= battery_alarm_next;
      check_low     <= check_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/srchk_out_stage.sv
`default_nettype none

module srchk_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire srchk_pkg::result_t result_in,
  output logic                    out_free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output srchk_pkg::result_t      result
);

  // Room for a new result when empty or when the held one is taken
  assign out_free = !out_valid || out_ready;

  // Hold valid until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  // Capture result
  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/settings_record_checker_core.sv
// Settings record checker.
// Input channel (in_valid/in_ready): one record byte per transfer, byte 0
// first; record_start high marks byte 0 and restarts checking. Without
// start marks, bytes are framed in groups of 32 from reset.
// Output channel (out_valid/out_ready): one result per 32-byte record with
// record_ok (magic, version, size, field ranges and CRC-32 all good) and
// the decoded sequence number and settings.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes the rotation limit
// (reset 4); always ready. Write it only while no record is in flight.
// Throughput: one byte per cycle unless the receiver stalls a result,
// set by the combinational CRC-32 byte update between the input register
// and the record state. Each verdict is registered in the output stage.
// Reset clears framing and both channel stages. When the receiver stalls,
// the result holds; the last byte of the next record waits in the input
// register and in_ready drops until the result is taken.
`default_nettype none

module settings_record_checker_core #(
  parameter int RecordBytes = srchk_pkg::RECORD_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] record_byte,
  input  wire logic       record_start,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            record_ok,
  output logic [31:0]     sequence_number,
  output logic [7:0]      rotation_code,
  output logic            key_sound_on,
  output logic            language_alt_on,
  output logic            battery_alarm_on
);

  srchk_pkg::item_t   in_item, item;
  srchk_pkg::result_t result_next, result;
  logic               item_valid, emit, out_free, advance;
  logic [7:0]         rotation_limit;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_limit <= srchk_pkg::ROT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rotation_limit <= cfg_data;
    end
  end

  assign in_item.data  = record_byte;
  assign in_item.start = record_start;

  // Process held byte unless its result has nowhere to go
  assign advance = item_valid && (!emit || out_free);

  srchk_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  srchk_tracker #(
    .RecordBytes (RecordBytes)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .go             (advance),
    .item           (item),
    .rotation_limit (rotation_limit),
    .emit           (emit),
    .result         (result_next)
  );

  srchk_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .result_in (result_next),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign record_ok        = result.record_ok;
  assign sequence_number  = result.sequence_number;
  assign rotation_code    = result.rotation_code;
  assign key_sound_on     = result.key_sound_on;
  assign language_alt_on  = result.language_alt_on;
  assign battery_alarm_on = result.battery_alarm_on;

endmodule

`default_nettype wire

### rtl/core/srchk_checker.sv
`default_nettype none

`include "settings_record_checker_core_assert.svh"

module srchk_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [7:0]  cfg_data,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  record_byte,
  input wire logic        record_start,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        record_ok,
  input wire logic [31:0] sequence_number,
  input wire logic [7:0]  rotation_code,
  input wire logic        key_sound_on,
  input wire logic        language_alt_on,
  input wire logic        battery_alarm_on
);

  // A stalled result stays offered
  `SRCHK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

  // A stalled result keeps its payload
  `SRCHK_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(record_ok) && $stable(sequence_number) && $stable(rotation_code) && $stable(key_sound_on) && $stable(language_alt_on) && $stable(battery_alarm_on))

  // Input backpressure only comes from a stalled result
  `SRCHK_ASSERT_MSG(a_ready_cause, !in_ready |-> out_valid && !out_ready, "in_ready low without output stall")

  // A fresh result follows an earlier input transfer through the input register
  `SRCHK_ASSERT_MSG(a_out_origin, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without input transfer")

endmodule

bind settings_record_checker_core srchk_checker u_srchk_checker (.*);

`default_nettype wire

### tb/sv/settings_record_checker_core_tb.sv
`timescale 1ns / 1ps

module settings_record_checker_core_tb;
  import srchk_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES = 64;
  localparam logic [15:0] SIZE_FIELD = 16'(RECORD_BYTES);

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] record_byte = '0;
  logic record_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic record_ok;
  logic [31:0] sequence_number;
  logic [7:0] rotation_code;
  logic key_sound_on;
  logic language_alt_on;
  logic battery_alarm_on;

  // Traffic shaping, in percent
  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  logic [7:0] cur_limit = ROT_LIMIT_RESET;

  // Predicted checker state
  logic [7:0] limit_m;
  logic [4:0] pos_m;
  logic [31:0] crc_m;
  logic [31:0] hdr_m;
  logic [31:0] seq_m;
  logic [31:0] set_m;
  logic [31:0] chk_m;
  logic good_m;
  result_t verdicts_due[$];

  int errors = 0;
  int idle_cycles = 0;
  int bytes_moved = 0;
  int verdicts_seen = 0;
  int verdicts_good = 0;

  settings_record_checker_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .record_byte(record_byte),
    .record_start(record_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .record_ok(record_ok),
    .sequence_number(sequence_number),
    .rotation_code(rotation_code),
    .key_sound_on(key_sound_on),
    .language_alt_on(language_alt_on),
    .battery_alarm_on(battery_alarm_on)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reflected CRC-32 update over one byte
  function automatic logic [31:0] crc32_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  task automatic clear_record_model();
    pos_m = '0;
    crc_m = CRC_INIT;
    good_m = 1'b1;
    hdr_m = '0;
    seq_m = '0;
    set_m = '0;
    chk_m = '0;
  endtask

  // Advance the predicted state by one accepted byte; queue a verdict on the last one
  task automatic absorb_record_byte(input logic [7:0] b, input logic s);
    logic [4:0] pos;
    logic [31:0] lane;
    result_t v;
    if (s || pos_m == 5'd0) clear_record_model();
    pos = pos_m;
    lane = {24'd0, b} << (8 * pos[1:0]);
    if (pos < 5'd28) crc_m = crc32_byte(crc_m, b);
    if (pos < 5'd8) begin
      if (pos == 5'd4) hdr_m = '0;
      hdr_m |= lane;
      if (pos == 5'd3 && hdr_m != MAGIC_WORD) good_m = 1'b0;
      if (pos == 5'd7 && hdr_m != {SIZE_FIELD, RECORD_VERSION}) good_m = 1'b0;
    end else if (pos < 5'd12) begin
      seq_m |= lane;
    end else if (pos < 5'd16) begin
      set_m |= lane;
      if (pos == 5'd12 && b >= limit_m) good_m = 1'b0;
      if (pos == 5'd13 && b > 8'd1) good_m = 1'b0;
      if ((pos == 5'd14 || pos == 5'd15) && b != FLAG_ERASED && b > 8'd1) good_m = 1'b0;
    end else if (pos >= 5'd28) begin
      chk_m |= lane;
    end
    if (pos == 5'd31) begin
      v.record_ok = good_m && ((crc_m ^ CRC_INIT) == chk_m);
      v.sequence_number = seq_m;
      v.rotation_code = set_m[7:0];
      v.key_sound_on = set_m[8];
      v.language_alt_on = (set_m[23:16] == 8'd1);
      v.battery_alarm_on = (set_m[31:24] == 8'd1);
      verdicts_due.push_back(v);
      pos_m = '0;
    end else begin
      pos_m = pos + 5'd1;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      errors++;
    end
  endtask

  // Track every transfer: update the model, check results, run the watchdog
  always @(posedge clk) begin : monitor_blk
    bit moved;
    result_t exp_v;
    moved = 1'b0;
    if (rst) begin
      limit_m = ROT_LIMIT_RESET;
      clear_record_model();
      idle_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_m = cfg_data;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          $error("result transfer with no verdict pending");
          errors++;
        end else begin
          exp_v = verdicts_due.pop_front();
          if (exp_v.record_ok) verdicts_good++;
          compare_field("record_ok", 32'(exp_v.record_ok), 32'(record_ok));
          compare_field("sequence_number", exp_v.sequence_number, sequence_number);
          compare_field("rotation_code", 32'(exp_v.rotation_code), 32'(rotation_code));
          compare_field("key_sound_on", 32'(exp_v.key_sound_on), 32'(key_sound_on));
          compare_field("language_alt_on", 32'(exp_v.language_alt_on),
                        32'(language_alt_on));
          compare_field("battery_alarm_on", 32'(exp_v.battery_alarm_on),
                        32'(battery_alarm_on));
        end
      end
      if (in_valid && in_ready) begin
        absorb_record_byte(record_byte, record_start);
        bytes_moved++;
        moved = 1'b1;
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $error("no transfer for %0d cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Stall the receiver at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Send one byte, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    record_byte <= b;
    record_start <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Send the first count bytes of a record, marking byte 0 if asked
  task automatic send_record(input logic [255:0] r, input bit mark, input int count);
    for (int i = 0; i < count; i++) send_byte(r[8*i +: 8], mark && i == 0);
  endtask

  // Drop valid and hold until every verdict has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rotation_limit(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cur_limit = v;
  endtask

  // Recompute the check word in bytes 28..31
  function automatic logic [255:0] seal_record(logic [255:0] r);
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 0; i < 28; i++) c = crc32_byte(c, r[8*i +: 8]);
    r[224 +: 32] = c ^ CRC_INIT;
    return r;
  endfunction

  // Build a well-formed record with random reserved bytes
  function automatic logic [255:0] make_record(logic [31:0] seq, logic [7:0] rot,
                                               logic [7:0] key, logic [7:0] lang,
                                               logic [7:0] batt);
    logic [255:0] r;
    r = '0;
    r[31:0] = MAGIC_WORD;
    r[47:32] = RECORD_VERSION;
    r[63:48] = SIZE_FIELD;
    r[95:64] = seq;
    r[103:96] = rot;
    r[111:104] = key;
    r[119:112] = lang;
    r[127:120] = batt;
    for (int i = 16; i < 28; i++) r[8*i +: 8] = 8'($urandom_range(0, 255));
    return seal_record(r);
  endfunction

  // Mostly 0, 1 or erased, sometimes anything
  function automatic logic [7:0] random_flag_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return 8'd0;
    if (pick < 60) return 8'd1;
    if (pick < 85) return FLAG_ERASED;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_valid_records();
    send_record(make_record(32'h0000_0000, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1, 32);
    send_record(make_record(32'hFFFF_FFFF, 8'd3, 8'd1, 8'd1, 8'd1), 1'b0, 32);
    send_record(make_record(32'h1234_5678, 8'd2, 8'd0, FLAG_ERASED, FLAG_ERASED), 1'b0, 32);
    wait_for_drain();
  endtask

  task automatic test_field_ranges();
    send_record(make_record(32'hA5A5_0001, 8'd4, 8'd0, 8'd0, 8'd0), 1'b1, 32);
    send_record(make_record(32'hA5A5_0002, 8'd1, 8'd2, 8'd0, 8'd0), 1'b0, 32);
    send_record(make_record(32'hA5A5_0003, 8'd1, 8'hFF, 8'd0, 8'd0), 1'b0, 32);
    send_record(make_record(32'hA5A5_0004, 8'd0, 8'd1, 8'd2, 8'd0), 1'b0, 32);
    send_record(make_record(32'hA5A5_0005, 8'd0, 8'd1, 8'd1, 8'hFE), 1'b0, 32);
    send_record(make_record(32'hA5A5_0006, 8'd3, 8'd1, FLAG_ERASED, 8'd0), 1'b0, 32);
    wait_for_drain();
  endtask

  task automatic test_header_and_crc();
    logic [255:0] r;
    // Wrong magic
    r = make_record(32'h0BAD_0001, 8'd1, 8'd0, 8'd1, 8'd0);
    r[7:0] = r[7:0] ^ 8'h01;
    send_record(seal_record(r), 1'b1, 32);
    // Wrong version
    r = make_record(32'h0BAD_0002, 8'd1, 8'd0, 8'd1, 8'd0);
    r[39:32] = 8'd2;
    send_record(seal_record(r), 1'b1, 32);
    // Wrong size field
    r = make_record(32'h0BAD_0003, 8'd1, 8'd0, 8'd1, 8'd0);
    r[55:48] = 8'd31;
    send_record(seal_record(r), 1'b1, 32);
    // Corrupt check word, leave it unsealed
    r = make_record(32'h0BAD_0004, 8'd1, 8'd0, 8'd1, 8'd0);
    r[231:224] = r[231:224] ^ 8'h80;
    send_record(r, 1'b1, 32);
    wait_for_drain();
  endtask

  task automatic test_framing();
    // Restart mid-record, then an unmarked erased record framed by count
    send_record(make_record(32'hC0DE_0001, 8'd0, 8'd0, 8'd0, 8'd0), 1'b1, 10);
    send_record(make_record(32'hC0DE_0002, 8'd1, 8'd1, 8'd0, 8'd1), 1'b1, 32);
    send_record({32{8'hFF}}, 1'b0, 32);
    send_record(make_record(32'hC0DE_0003, 8'd2, 8'd0, 8'd1, 8'd1), 1'b0, 32);
    wait_for_drain();
  endtask

  task automatic test_rotation_limit_sweep();
    write_rotation_limit(8'd1);
    send_record(make_record(32'h0001_0000, 8'd0, 8'd1, 8'd0, 8'd0), 1'b1, 32);
    send_record(make_record(32'h0001_0001, 8'd1, 8'd1, 8'd0, 8'd0), 1'b1, 32);
    wait_for_drain();
    write_rotation_limit(8'd255);
    send_record(make_record(32'h00FF_0000, 8'd254, 8'd0, 8'd1, 8'd1), 1'b1, 32);
    send_record(make_record(32'h00FF_0001, 8'd255, 8'd0, 8'd1, 8'd1), 1'b1, 32);
    wait_for_drain();
    write_rotation_limit(8'd128);
    send_record(make_record(32'h0080_0000, 8'd127, 8'd0, 8'd0, 8'd1), 1'b1, 32);
    send_record(make_record(32'h0080_0001, 8'd200, 8'd0, 8'd0, 8'd1), 1'b1, 32);
    wait_for_drain();
  endtask

  // Mix of well-formed, noisy and cut-short records under one traffic setting
  task automatic run_random_phase(input int gap, input int stall, input logic [7:0] lim);
    int sent;
    int pick;
    int cut;
    bit mark_needed;
    bit mark;
    logic [7:0] rot;
    logic [7:0] key;
    logic [255:0] r;
    sender_gap_pct = gap;
    receiver_stall_pct = stall;
    write_rotation_limit(lim);
    sent = 0;
    mark_needed = 1'b1;
    while (sent < PHASE_BYTES) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) rot = 8'($urandom_range(0, cur_limit - 1));
      else rot = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 85) key = 8'($urandom_range(0, 1));
      else key = 8'($urandom_range(0, 255));
      r = make_record($urandom, rot, key, random_flag_byte(), random_flag_byte());
      if ($urandom_range(0, 99) < 20) begin
        cut = $urandom_range(0, 255);
        r[cut] = ~r[cut];
      end
      mark = mark_needed || ($urandom_range(0, 1) == 1);
      if (pick < 70) begin
        send_record(r, mark, 32);
        sent += 32;
        mark_needed = 1'b0;
      end else if (pick < 85) begin
        r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        send_record(r, mark, 32);
        sent += 32;
        mark_needed = 1'b0;
      end else begin
        cut = $urandom_range(1, 31);
        send_record(r, mark, cut);
        sent += cut;
        mark_needed = 1'b1;
      end
    end
    // Close the phase on a record boundary
    send_record(make_record($urandom, 8'd0, 8'd1, 8'd1, 8'd1), 1'b1, 32);
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 8'd255);
    run_random_phase(52, 0, 8'd1);
    run_random_phase(0, 52, 8'($urandom_range(2, 254)));
    run_random_phase(23, 23, ROT_LIMIT_RESET);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_valid_records();
    test_field_ranges();
    test_header_and_crc();
    test_framing();
    test_rotation_limit_sweep();
    test_random_traffic();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdicts_due.size() != 0) begin
      $error("%0d verdicts never arrived", verdicts_due.size());
      errors++;
    end
    $display("Checked %0d record verdicts (%0d good) over %0d byte transfers,",
             verdicts_seen, verdicts_good, bytes_moved);
    $display("with header, range, CRC and framing faults at five rotation limits.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
